// ===== design/alle_pkg.sv =====
// Shared types and constants for the array linked list engine.
// No dependencies; compiled first.
package alle_pkg;

    // Link field width and the null link code
    localparam int                LINK_W         = 7;
    localparam logic [LINK_W-1:0] NULL_LINK      = 7'd127;
    localparam int                NODE_COUNT_DEF = 64;
    localparam int                DATA_W         = 32;

    // Request opcodes; codes above OP_READ behave as read out
    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_MODIFY = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_LINK,
        S_RD,
        S_CHK,
        S_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;        // capture request fields
        logic    alloc;       // write new node, update head/tail/used
        logic    tail_link;   // link old tail to the new node
        logic    walk_init;   // start a walk at head
        logic    rd;          // read node at cur
        logic    advance;     // step to the next node
        logic    hit;         // apply delete or modify at cur
        logic    set_status;  // latch final status
        status_t status;
        logic    emit_elem;   // emit element read at cur
        logic    emit_final;  // emit single closing result
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       need_tail_link;
        logic       cur_ok;
        logic       match;
        logic       read_end;
        logic       out_free;
    } stat_t;

endpackage

// ===== design/alle_if.sv =====
// Request and response channel interfaces for the linked list engine.
// Depends on alle_pkg.
interface alle_req_if;
    import alle_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [2:0]               op;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;

    modport source (output valid, output op, output value, output new_value, input ready);
    modport sink   (input valid, input op, input value, input new_value, output ready);
endinterface

interface alle_rsp_if;
    import alle_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_value;
    logic [1:0]               status;
    logic                     last;

    modport source (output valid, output out_value, output status, output last, input ready);
    modport sink   (input valid, input out_value, input status, input last, output ready);
endinterface

// ===== design/alle_datapath.sv =====
// Datapath of the linked list engine: node store, pointers, walk registers
// and the output register. Depends on alle_pkg.
module alle_datapath #(
    parameter int NODE_COUNT = alle_pkg::NODE_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  alle_pkg::cmd_t                    cmd,
    output alle_pkg::stat_t                   stat,
    input  logic [2:0]                        op,
    input  logic signed [alle_pkg::DATA_W-1:0] value,
    input  logic signed [alle_pkg::DATA_W-1:0] new_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [alle_pkg::DATA_W-1:0] out_value,
    output logic [1:0]                        out_status,
    output logic                              out_last
);
    import alle_pkg::*;

    localparam int                IDX_W    = $clog2(NODE_COUNT);
    localparam int                CNT_W    = $clog2(NODE_COUNT + 1);
    localparam logic [LINK_W-1:0] NODE_LIM = LINK_W'(NODE_COUNT);
    localparam logic [CNT_W:0]    STEP_LIM = (CNT_W + 1)'(NODE_COUNT);

    function automatic logic is_node(input logic [LINK_W-1:0] p);
        return p < NODE_LIM;
    endfunction

    // Node store
    logic [DATA_W-1:0] values_mem [NODE_COUNT];
    logic [LINK_W-1:0] links_mem  [NODE_COUNT];

    // Request registers
    logic [2:0]        op_reg;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] nval_reg;

    // List pointers
    logic [LINK_W-1:0] head_reg;
    logic [LINK_W-1:0] tail_reg;
    logic [CNT_W-1:0]  used_reg;

    // Walk state
    logic [LINK_W-1:0] cur_reg;
    logic [LINK_W-1:0] prev_reg;
    logic [CNT_W-1:0]  steps_reg;
    logic [DATA_W-1:0] rd_val_reg;
    logic [LINK_W-1:0] rd_link_reg;
    status_t           fin_status_reg;

    // Output register
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    status_t           out_status_reg;
    logic              out_last_reg;

    logic [LINK_W-1:0] new_idx;
    logic              head_ok;
    logic              tail_ok;
    logic              prev_ok;

    logic              val_we;
    logic [IDX_W-1:0]  val_waddr;
    logic [DATA_W-1:0] val_wdata;
    logic              link_we;
    logic [IDX_W-1:0]  link_waddr;
    logic [LINK_W-1:0] link_wdata;

    assign new_idx = LINK_W'(used_reg);
    assign head_ok = is_node(head_reg);
    assign tail_ok = is_node(tail_reg);
    assign prev_ok = is_node(prev_reg);

    // Status toward the controller
    always_comb
    begin
        stat.op             = op_reg;
        stat.full           = (used_reg == CNT_W'(NODE_COUNT));
        stat.need_tail_link = (op_reg == OP_APPEND) && head_ok && tail_ok;
        stat.cur_ok         = ({1'b0, steps_reg} < STEP_LIM) && is_node(cur_reg);
        stat.match          = (rd_val_reg == val_reg);
        stat.read_end       = (({1'b0, steps_reg} + 1'b1) >= STEP_LIM) || !is_node(rd_link_reg);
        stat.out_free       = !out_valid_reg || out_ready;
    end

    // Store write selection
    always_comb
    begin
        val_we     = 1'b0;
        val_waddr  = used_reg[IDX_W-1:0];
        val_wdata  = val_reg;
        link_we    = 1'b0;
        link_waddr = used_reg[IDX_W-1:0];
        link_wdata = (op_reg == OP_APPEND) ? NULL_LINK : head_reg;
        priority if (cmd.alloc)
        begin
            val_we  = 1'b1;
            link_we = 1'b1;
        end
        else if (cmd.tail_link)
        begin
            link_we    = 1'b1;
            link_waddr = prev_reg[IDX_W-1:0];
            link_wdata = cur_reg;
        end
        else if (cmd.hit)
        begin
            if (op_reg == OP_MODIFY)
            begin
                val_we    = 1'b1;
                val_waddr = cur_reg[IDX_W-1:0];
                val_wdata = nval_reg;
            end
            else if (prev_ok)
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg[IDX_W-1:0];
                link_wdata = rd_link_reg;
            end
        end
    end

    // Value store
    always_ff @(posedge clk)
    begin
        if (val_we)
            values_mem[val_waddr] <= val_wdata;
        if (cmd.rd)
            rd_val_reg <= values_mem[cur_reg[IDX_W-1:0]];
    end

    // Link store
    always_ff @(posedge clk)
    begin
        if (link_we)
            links_mem[link_waddr] <= link_wdata;
        if (cmd.rd)
            rd_link_reg <= links_mem[cur_reg[IDX_W-1:0]];
    end

    // Head, tail and allocation count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= NULL_LINK;
            tail_reg <= NULL_LINK;
            used_reg <= '0;
        end
        else if (cmd.alloc)
        begin
            used_reg <= used_reg + 1'b1;
            if (op_reg == OP_APPEND)
            begin
                if (!(head_ok && tail_ok))
                    head_reg <= new_idx;
                tail_reg <= new_idx;
            end
            else
            begin
                if (!head_ok)
                    tail_reg <= new_idx;
                head_reg <= new_idx;
            end
        end
        else if (cmd.hit && (op_reg == OP_DELETE))
        begin
            if (!prev_ok)
                head_reg <= rd_link_reg;
            if (cur_reg == tail_reg)
                tail_reg <= prev_reg;
        end
    end

    // Request capture and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            val_reg  <= value;
            nval_reg <= new_value;
        end
        if (cmd.walk_init)
        begin
            cur_reg   <= head_reg;
            prev_reg  <= NULL_LINK;
            steps_reg <= '0;
        end
        else if (cmd.alloc)
        begin
            cur_reg  <= new_idx;
            prev_reg <= tail_reg;
        end
        else if (cmd.advance)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= rd_link_reg;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.set_status)
            fin_status_reg <= cmd.status;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_elem || cmd.emit_final)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_elem)
        begin
            out_value_reg  <= rd_val_reg;
            out_status_reg <= STAT_DONE;
            out_last_reg   <= stat.read_end;
        end
        else if (cmd.emit_final)
        begin
            out_value_reg  <= '0;
            out_status_reg <= fin_status_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

`ifndef SYNTHESIS
    // Allocation never runs past the store
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(NODE_COUNT))
        else $error("node count beyond store size");

    // Head and tail are null together
    a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NULL_LINK) == (tail_reg == NULL_LINK))
        else $error("head and tail disagree on empty list");

    // Each allocation takes exactly one node
    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |=> (used_reg == $past(used_reg) + 1'b1))
        else $error("allocation count did not advance by one");
`endif

endmodule

// ===== design/alle_ctrl.sv =====
// Controller of the linked list engine: sequences allocation, walks and
// result emission. Depends on alle_pkg.
module alle_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  alle_pkg::stat_t stat,
    output alle_pkg::cmd_t  cmd
);
    import alle_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   is_add;
    logic   is_walk;

    assign is_add  = (stat.op == OP_APPEND) || (stat.op == OP_INSERT);
    assign is_walk = (stat.op == OP_DELETE) || (stat.op == OP_MODIFY);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = STAT_DONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (is_add)
                begin
                    cmd.set_status = 1'b1;
                    if (stat.full)
                    begin
                        cmd.status = STAT_FULL;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.alloc  = 1'b1;
                        state_next = stat.need_tail_link ? S_LINK : S_FINISH;
                    end
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_LINK:
            begin
                cmd.tail_link = 1'b1;
                state_next    = S_FINISH;
            end
            S_RD:
            begin
                if (stat.cur_ok)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CHK;
                end
                else
                begin
                    // walk ran off the list: no match, or an empty read out
                    cmd.set_status = 1'b1;
                    cmd.status     = is_walk ? STAT_NOT_FOUND : STAT_EMPTY;
                    state_next     = S_FINISH;
                end
            end
            S_CHK:
            begin
                if (is_walk)
                begin
                    if (stat.match)
                    begin
                        cmd.hit        = 1'b1;
                        cmd.set_status = 1'b1;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_RD;
                    end
                end
                else if (stat.out_free)
                begin
                    cmd.emit_elem = 1'b1;
                    cmd.advance   = 1'b1;
                    state_next    = stat.read_end ? S_IDLE : S_RD;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // Results are only loaded into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_elem || cmd.emit_final) |-> stat.out_free)
        else $error("result loaded over a pending result");

    // Tail link always follows an allocation
    a_link_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK) |-> ($past(state_reg) == S_DISPATCH))
        else $error("tail link outside an append");

    // Delete or modify applies only on a matching node
    a_hit_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hit |-> (stat.match && (state_reg == S_CHK)))
        else $error("update applied without a match");
`endif

endmodule

// ===== design/array_linked_list_engine.sv =====
// Linked list engine over a fixed store of NODE_COUNT nodes. Append and insert allocate
// the node in S_DISPATCH; an append to a non-empty list then links the old tail in
// S_LINK, and each result waits on the output register. Delete and modify walk the
// list one node at a time, since each link must come back from the registered link
// store read before the next node can be addressed. Read out emits its items from the
// same walk loop and waits whenever the consumer stalls. One request is in work at a
// time; a new request is taken once the previous one has put its final result in the
// output register. Depends on alle_pkg, alle_if, alle_ctrl and alle_datapath.
module array_linked_list_engine #(
    parameter int NODE_COUNT = alle_pkg::NODE_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    alle_req_if.sink        req,
    alle_rsp_if.source      rsp
);
    import alle_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer
    alle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Node store and pointers
    alle_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (req.op),
        .value      (req.value),
        .new_value  (req.new_value),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_value  (rsp.out_value),
        .out_status (rsp.status),
        .out_last   (rsp.last)
    );

endmodule
